FILE: design/ppt_pkg.sv
// ppt_pkg: shared types and constants for the polyline position block
// payload structs, datapath micro-operations, status bundle, register indexes
// no dependencies
package ppt_pkg;

    localparam int COORD_W    = 16;
    localparam int LEN_W      = 20;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // shared restoring divider
    localparam int DIV_NW = 53;
    localparam int DIV_DW = 32;
    localparam int DIV_SW = 6;
    localparam logic [DIV_SW-1:0] DIV_STEPS_FOLD = 6'd40;
    localparam logic [DIV_SW-1:0] DIV_STEPS_LEN  = 6'd53;
    localparam logic [DIV_SW-1:0] DIV_STEPS_SEG  = 6'd37;

    localparam logic [1:0] OPC_CLEAR  = 2'd0;
    localparam logic [1:0] OPC_APPEND = 2'd1;
    localparam logic [1:0] OPC_QTIME  = 2'd2;
    localparam logic [1:0] OPC_QLEN   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_START_TIME = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_TIME   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPATIAL    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_X    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_Y    = 4'd7;

    typedef struct packed {
        logic [1:0]          opcode;
        logic signed [31:0]  query_time;
        logic [19:0]         query_length;
        logic signed [15:0]  seg_from_x;
        logic signed [15:0]  seg_from_y;
        logic signed [15:0]  seg_to_x;
        logic signed [15:0]  seg_to_y;
        logic [19:0]         seg_total_length;
    } t_in;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } t_out;

    typedef enum logic [4:0] {
        UOP_NONE,
        UOP_LATCH,
        UOP_CLEAR,
        UOP_APPEND,
        UOP_T_MUL,
        UOP_T_DIV,
        UOP_T_MUL2,
        UOP_T_DIV2,
        UOP_T_LEN,
        UOP_LEN_ZERO,
        UOP_RES_START,
        UOP_RES_FINAL,
        UOP_RD_FIRST,
        UOP_RD_LAST,
        UOP_RES_FROM,
        UOP_RES_TO,
        UOP_SRCH_INIT,
        UOP_SRCH_MID,
        UOP_SRCH_CMP,
        UOP_IDX,
        UOP_NEXT,
        UOP_PREV,
        UOP_I_MUL,
        UOP_I_DIV,
        UOP_I_SAVE,
        UOP_PUT
    } t_uop;

    typedef struct packed {
        t_uop uop;
        logic axis;     // 0 x, 1 y
    } t_cmd;

    typedef struct packed {
        logic [1:0] opcode;
        logic       empty;
        logic       t_before;
        logic       t_after;
        logic       t_zero;
        logic       len_zero;
        logic       len_past;
        logic       lo_lt_hi;
        logic       seg_flat;
        logic       div_busy;
        logic       out_free;
    } t_sts;

endpackage

FILE: design/ppt_div.sv
// ppt_div: restoring divider, one quotient bit per cycle
// numerator is left aligned, steps sets how many top bits are used
// depends on ppt_pkg
module ppt_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ppt_pkg::DIV_NW-1:0]     i_num,
    input  logic [ppt_pkg::DIV_DW-1:0]     i_den,
    input  logic [ppt_pkg::DIV_SW-1:0]     i_steps,
    output logic                           o_busy,
    output logic [ppt_pkg::DIV_NW-1:0]     o_quo,
    output logic [ppt_pkg::DIV_DW-1:0]     o_rem
);

    logic                         r_busy;
    logic [ppt_pkg::DIV_SW-1:0]   r_cnt;
    logic [ppt_pkg::DIV_NW-1:0]   r_num;
    logic [ppt_pkg::DIV_NW-1:0]   r_quo;
    logic [ppt_pkg::DIV_DW-1:0]   r_den;
    logic [ppt_pkg::DIV_DW-1:0]   r_rem;
    logic [ppt_pkg::DIV_DW:0]     w_trial;
    logic [ppt_pkg::DIV_DW:0]     w_sub;
    logic                         w_ge;

    assign w_trial = {r_rem, r_num[ppt_pkg::DIV_NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_sub   = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == ppt_pkg::DIV_SW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[ppt_pkg::DIV_NW-2:0], 1'b0};
            r_quo <= {r_quo[ppt_pkg::DIV_NW-2:0], w_ge};
            r_rem <= w_ge ? w_sub[ppt_pkg::DIV_DW-1:0] : w_trial[ppt_pkg::DIV_DW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

FILE: design/ppt_dp.sv
// ppt_dp: datapath with segment table, config registers, search and arithmetic
// runs one micro-operation per cycle as the controller commands
// depends on ppt_pkg and ppt_div
module ppt_dp #(
    parameter int MAX_SEGMENTS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ppt_pkg::t_cmd                     i_cmd,
    output ppt_pkg::t_sts                     o_sts,
    input  ppt_pkg::t_in                      i_in_data,
    input  logic                              i_cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ppt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output ppt_pkg::t_out                     o_out_data
);

    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    // config
    logic signed [31:0] r_start_time, r_end_time;
    logic [7:0]         r_repeat;
    logic [19:0]        r_spatial;
    logic signed [15:0] r_start_x, r_start_y, r_final_x, r_final_y;

    // table
    logic [63:0]   r_pts_mem [MAX_SEGMENTS];
    logic [19:0]   r_cum_mem [MAX_SEGMENTS];
    logic [CW-1:0] r_count;
    logic [63:0]   r_pts_q;
    logic [19:0]   r_cum_q;

    ppt_pkg::t_in       r_item;
    logic [19:0]        r_len;
    logic [CW-1:0]      r_lo, r_hi;
    logic [AW-1:0]      r_mid, r_idx;
    logic [19:0]        r_next, r_prev;
    logic [ppt_pkg::DIV_NW-1:0] r_prod;
    logic signed [37:0] r_iprod;
    logic               r_neg;
    logic signed [15:0] r_res_x, r_res_y;
    logic               r_out_valid;
    ppt_pkg::t_out      r_out;

    logic signed [32:0] w_elapsed, w_dur;
    logic [39:0]        w_e;
    logic [31:0]        w_pn;
    logic [51:0]        w_lp;
    logic [CW-1:0]      w_mid, w_idx;
    logic [AW-1:0]      w_raddr;
    logic               w_rd, w_rd_pts;
    logic signed [15:0] w_from, w_to;
    logic signed [16:0] w_diff;
    logic signed [20:0] w_num, w_den;
    logic signed [37:0] w_iprod;
    logic [37:0]        w_pmag;
    logic [20:0]        w_dmag;
    logic [36:0]        w_inum;
    logic signed [38:0] w_sq, w_sum;
    logic signed [15:0] w_sat;
    logic               w_full;

    logic                         w_div_start;
    logic [ppt_pkg::DIV_NW-1:0]   w_div_num;
    logic [ppt_pkg::DIV_DW-1:0]   w_div_den;
    logic [ppt_pkg::DIV_SW-1:0]   w_div_steps;
    logic                         w_div_busy;
    logic [ppt_pkg::DIV_NW-1:0]   w_div_quo;
    logic [ppt_pkg::DIV_DW-1:0]   w_div_rem;

    ppt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .i_steps (w_div_steps),
        .o_busy  (w_div_busy),
        .o_quo   (w_div_quo),
        .o_rem   (w_div_rem)
    );

    // time folding
    assign w_elapsed = {r_item.query_time[31], r_item.query_time}
                     - {r_start_time[31], r_start_time};
    assign w_dur     = {r_end_time[31], r_end_time} - {r_start_time[31], r_start_time};
    assign w_e       = w_elapsed[31:0] * r_repeat;
    // odd quotient means the backward pass
    assign w_pn      = w_div_quo[0] ? (w_dur[31:0] - w_div_rem) : w_div_rem;
    assign w_lp      = r_spatial * w_pn;

    // search
    assign w_mid  = r_lo + ((r_hi - r_lo) >> 1);
    assign w_idx  = (r_lo >= r_count) ? (r_count - 1'b1) : r_lo;
    assign w_full = r_count == CW'(MAX_SEGMENTS);

    // segment interpolation
    assign w_from  = i_cmd.axis ? $signed(r_pts_q[31:16]) : $signed(r_pts_q[15:0]);
    assign w_to    = i_cmd.axis ? $signed(r_pts_q[63:48]) : $signed(r_pts_q[47:32]);
    assign w_diff  = {w_to[15], w_to} - {w_from[15], w_from};
    assign w_num   = $signed({1'b0, r_len}) - $signed({1'b0, r_prev});
    assign w_den   = $signed({1'b0, r_next}) - $signed({1'b0, r_prev});
    assign w_iprod = w_diff * w_num;
    assign w_pmag  = r_iprod[37] ? 38'(-r_iprod) : 38'(r_iprod);
    assign w_dmag  = w_den[20] ? 21'(-w_den) : 21'(w_den);
    assign w_inum  = w_pmag[36:0] + {17'b0, w_dmag[20:1]};
    assign w_sq    = r_neg ? -$signed({2'b0, w_div_quo[36:0]})
                           :  $signed({2'b0, w_div_quo[36:0]});
    assign w_sum   = w_sq + {{23{w_from[15]}}, w_from};

    always_comb begin
        if (w_sum > 39'sd32767) begin
            w_sat = 16'sh7fff;
        end else if (w_sum < -39'sd32768) begin
            w_sat = -16'sh8000;
        end else begin
            w_sat = w_sum[15:0];
        end
    end

    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = w_dur[31:0];
        w_div_steps = ppt_pkg::DIV_STEPS_FOLD;
        unique case (i_cmd.uop)
            ppt_pkg::UOP_T_DIV: begin
                w_div_start = 1'b1;
                w_div_num   = {r_prod[39:0], 13'b0};
            end
            ppt_pkg::UOP_T_DIV2: begin
                w_div_start = 1'b1;
                w_div_num   = r_prod + {22'b0, w_dur[31:1]};
                w_div_steps = ppt_pkg::DIV_STEPS_LEN;
            end
            ppt_pkg::UOP_I_DIV: begin
                w_div_start = 1'b1;
                w_div_num   = {w_inum, 16'b0};
                w_div_den   = {11'b0, w_dmag};
                w_div_steps = ppt_pkg::DIV_STEPS_SEG;
            end
            default: ;
        endcase
    end

    // table read address
    always_comb begin
        w_rd     = 1'b1;
        w_rd_pts = 1'b1;
        unique case (i_cmd.uop)
            ppt_pkg::UOP_RD_FIRST: w_raddr = '0;
            ppt_pkg::UOP_RD_LAST:  w_raddr = AW'(r_count - 1'b1);
            ppt_pkg::UOP_SRCH_MID: w_raddr = AW'(w_mid);
            ppt_pkg::UOP_IDX:      w_raddr = AW'(w_idx);
            ppt_pkg::UOP_NEXT: begin
                // previous entry: cumulative length only, keep the points
                w_raddr  = r_idx - 1'b1;
                w_rd_pts = 1'b0;
            end
            default: begin
                w_raddr  = '0;
                w_rd     = 1'b0;
                w_rd_pts = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.uop == ppt_pkg::UOP_APPEND && !w_full) begin
            r_pts_mem[AW'(r_count)] <= {r_item.seg_to_y, r_item.seg_to_x,
                                        r_item.seg_from_y, r_item.seg_from_x};
            r_cum_mem[AW'(r_count)] <= r_item.seg_total_length;
        end
        if (w_rd) begin
            r_cum_q <= r_cum_mem[w_raddr];
        end
        if (w_rd_pts) begin
            r_pts_q <= r_pts_mem[w_raddr];
        end
    end

    // control state: config, fill count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_time <= '0;
            r_end_time   <= '0;
            r_repeat     <= 8'd1;
            r_spatial    <= '0;
            r_start_x    <= '0;
            r_start_y    <= '0;
            r_final_x    <= '0;
            r_final_y    <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ppt_pkg::CFG_START_TIME: r_start_time <= i_cfg_data;
                    ppt_pkg::CFG_END_TIME:   r_end_time   <= i_cfg_data;
                    ppt_pkg::CFG_REPEAT:     r_repeat     <= i_cfg_data[7:0];
                    ppt_pkg::CFG_SPATIAL:    r_spatial    <= i_cfg_data[19:0];
                    ppt_pkg::CFG_START_X:    r_start_x    <= i_cfg_data[15:0];
                    ppt_pkg::CFG_START_Y:    r_start_y    <= i_cfg_data[15:0];
                    ppt_pkg::CFG_FINAL_X:    r_final_x    <= i_cfg_data[15:0];
                    ppt_pkg::CFG_FINAL_Y:    r_final_y    <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.uop == ppt_pkg::UOP_CLEAR) begin
                r_count <= '0;
            end else if (i_cmd.uop == ppt_pkg::UOP_APPEND && !w_full) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.uop == ppt_pkg::UOP_PUT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.uop)
            ppt_pkg::UOP_LATCH: begin
                r_item <= i_in_data;
                r_len  <= i_in_data.query_length;
            end
            ppt_pkg::UOP_T_MUL:    r_prod <= {13'b0, w_e};
            ppt_pkg::UOP_T_MUL2:   r_prod <= {1'b0, w_lp};
            ppt_pkg::UOP_T_LEN:    r_len  <= w_div_quo[19:0];
            ppt_pkg::UOP_LEN_ZERO: r_len  <= '0;
            ppt_pkg::UOP_RES_START: begin
                r_res_x <= r_start_x;
                r_res_y <= r_start_y;
            end
            ppt_pkg::UOP_RES_FINAL: begin
                r_res_x <= r_final_x;
                r_res_y <= r_final_y;
            end
            ppt_pkg::UOP_RES_FROM: begin
                r_res_x <= r_pts_q[15:0];
                r_res_y <= r_pts_q[31:16];
            end
            ppt_pkg::UOP_RES_TO: begin
                r_res_x <= r_pts_q[47:32];
                r_res_y <= r_pts_q[63:48];
            end
            ppt_pkg::UOP_SRCH_INIT: begin
                r_lo <= '0;
                r_hi <= r_count;
            end
            ppt_pkg::UOP_SRCH_MID: r_mid <= AW'(w_mid);
            ppt_pkg::UOP_SRCH_CMP: begin
                if (r_cum_q < r_len) begin
                    r_lo <= CW'(r_mid) + 1'b1;
                end else begin
                    r_hi <= CW'(r_mid);
                end
            end
            ppt_pkg::UOP_IDX:  r_idx  <= AW'(w_idx);
            ppt_pkg::UOP_NEXT: r_next <= r_cum_q;
            ppt_pkg::UOP_PREV: r_prev <= (r_idx == '0) ? 20'd0 : r_cum_q;
            ppt_pkg::UOP_I_MUL: r_iprod <= w_iprod;
            ppt_pkg::UOP_I_DIV: r_neg   <= r_iprod[37] ^ w_den[20];
            ppt_pkg::UOP_I_SAVE: begin
                if (i_cmd.axis) begin
                    r_res_y <= w_sat;
                end else begin
                    r_res_x <= w_sat;
                end
            end
            ppt_pkg::UOP_PUT: begin
                r_out.pos_x <= r_res_x;
                r_out.pos_y <= r_res_y;
            end
            default: ;
        endcase
    end

    assign o_sts.opcode   = r_item.opcode;
    assign o_sts.empty    = r_count == '0;
    assign o_sts.t_before = r_item.query_time < r_start_time;
    assign o_sts.t_after  = r_item.query_time > r_end_time;
    assign o_sts.t_zero   = (w_dur[31:0] == '0) || (r_repeat == '0);
    assign o_sts.len_zero = r_len == '0;
    assign o_sts.len_past = r_len >= r_cum_q;
    assign o_sts.lo_lt_hi = r_lo < r_hi;
    assign o_sts.seg_flat = r_next == r_prev;
    assign o_sts.div_busy = w_div_busy;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: design/ppt_ctrl.sv
// ppt_ctrl: sequencer for table updates, time folding, search and interpolation
// issues one datapath micro-operation per cycle from datapath status
// depends on ppt_pkg
module ppt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  ppt_pkg::t_sts  i_sts,
    output logic           o_in_stall,
    output ppt_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DISP,
        S_T_DIV, S_T_W1, S_T_DIV2, S_T_W2,
        S_L_BEGIN, S_L_FIRST, S_L_LAST, S_L_SRCH, S_L_CMP,
        S_L_NEXT, S_L_PREV, S_L_CHK,
        S_X_DIV, S_X_W, S_Y_MUL, S_Y_DIV, S_Y_W,
        S_PUT
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.uop  = ppt_pkg::UOP_NONE;
        o_cmd.axis = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.uop = ppt_pkg::UOP_LATCH;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_sts.opcode)
                    ppt_pkg::OPC_CLEAR: begin
                        o_cmd.uop = ppt_pkg::UOP_CLEAR;
                        n_state   = S_IDLE;
                    end
                    ppt_pkg::OPC_APPEND: begin
                        o_cmd.uop = ppt_pkg::UOP_APPEND;
                        n_state   = S_IDLE;
                    end
                    ppt_pkg::OPC_QTIME: begin
                        priority if (i_sts.empty || i_sts.t_before) begin
                            o_cmd.uop = ppt_pkg::UOP_RES_START;
                            n_state   = S_PUT;
                        end else if (i_sts.t_after) begin
                            o_cmd.uop = ppt_pkg::UOP_RES_FINAL;
                            n_state   = S_PUT;
                        end else if (i_sts.t_zero) begin
                            o_cmd.uop = ppt_pkg::UOP_LEN_ZERO;
                            n_state   = S_L_BEGIN;
                        end else begin
                            o_cmd.uop = ppt_pkg::UOP_T_MUL;
                            n_state   = S_T_DIV;
                        end
                    end
                    default: n_state = S_L_BEGIN;
                endcase
            end
            S_T_DIV: begin
                o_cmd.uop = ppt_pkg::UOP_T_DIV;
                n_state   = S_T_W1;
            end
            S_T_W1: begin
                if (!i_sts.div_busy) begin
                    o_cmd.uop = ppt_pkg::UOP_T_MUL2;
                    n_state   = S_T_DIV2;
                end
            end
            S_T_DIV2: begin
                o_cmd.uop = ppt_pkg::UOP_T_DIV2;
                n_state   = S_T_W2;
            end
            S_T_W2: begin
                if (!i_sts.div_busy) begin
                    o_cmd.uop = ppt_pkg::UOP_T_LEN;
                    n_state   = S_L_BEGIN;
                end
            end
            S_L_BEGIN: begin
                priority if (i_sts.empty) begin
                    o_cmd.uop = ppt_pkg::UOP_RES_START;
                    n_state   = S_PUT;
                end else if (i_sts.len_zero) begin
                    o_cmd.uop = ppt_pkg::UOP_RD_FIRST;
                    n_state   = S_L_FIRST;
                end else begin
                    o_cmd.uop = ppt_pkg::UOP_RD_LAST;
                    n_state   = S_L_LAST;
                end
            end
            S_L_FIRST: begin
                o_cmd.uop = ppt_pkg::UOP_RES_FROM;
                n_state   = S_PUT;
            end
            S_L_LAST: begin
                if (i_sts.len_past) begin
                    o_cmd.uop = ppt_pkg::UOP_RES_TO;
                    n_state   = S_PUT;
                end else begin
                    o_cmd.uop = ppt_pkg::UOP_SRCH_INIT;
                    n_state   = S_L_SRCH;
                end
            end
            S_L_SRCH: begin
                if (i_sts.lo_lt_hi) begin
                    o_cmd.uop = ppt_pkg::UOP_SRCH_MID;
                    n_state   = S_L_CMP;
                end else begin
                    o_cmd.uop = ppt_pkg::UOP_IDX;
                    n_state   = S_L_NEXT;
                end
            end
            S_L_CMP: begin
                o_cmd.uop = ppt_pkg::UOP_SRCH_CMP;
                n_state   = S_L_SRCH;
            end
            S_L_NEXT: begin
                o_cmd.uop = ppt_pkg::UOP_NEXT;
                n_state   = S_L_PREV;
            end
            S_L_PREV: begin
                o_cmd.uop = ppt_pkg::UOP_PREV;
                n_state   = S_L_CHK;
            end
            S_L_CHK: begin
                // zero length segment gives its start point
                if (i_sts.seg_flat) begin
                    o_cmd.uop = ppt_pkg::UOP_RES_FROM;
                    n_state   = S_PUT;
                end else begin
                    o_cmd.uop = ppt_pkg::UOP_I_MUL;
                    n_state   = S_X_DIV;
                end
            end
            S_X_DIV: begin
                o_cmd.uop = ppt_pkg::UOP_I_DIV;
                n_state   = S_X_W;
            end
            S_X_W: begin
                if (!i_sts.div_busy) begin
                    o_cmd.uop = ppt_pkg::UOP_I_SAVE;
                    n_state   = S_Y_MUL;
                end
            end
            S_Y_MUL: begin
                o_cmd.uop  = ppt_pkg::UOP_I_MUL;
                o_cmd.axis = 1'b1;
                n_state    = S_Y_DIV;
            end
            S_Y_DIV: begin
                o_cmd.uop  = ppt_pkg::UOP_I_DIV;
                o_cmd.axis = 1'b1;
                n_state    = S_Y_W;
            end
            S_Y_W: begin
                o_cmd.axis = 1'b1;
                if (!i_sts.div_busy) begin
                    o_cmd.uop = ppt_pkg::UOP_I_SAVE;
                    n_state   = S_PUT;
                end
            end
            S_PUT: begin
                if (i_sts.out_free) begin
                    o_cmd.uop = ppt_pkg::UOP_PUT;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule

FILE: design/polyline_position_at_time.sv
// polyline_position_at_time: top level, position along a segment table by time or length
// joins the sequencer and the datapath; depends on ppt_pkg, ppt_ctrl, ppt_dp
//
//  channel   handshake                    beat
//  in        i_in_valid / o_in_stall      i_in_data  (ppt_pkg::t_in)
//  out       o_out_valid / i_out_stall    o_out_data (ppt_pkg::t_out)
//  cfg       i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// one item at a time; a clear or an append is latched, then done in the dispatch state
// length query: empty table, zero length or a length at or past the end answers directly,
//   else a binary search over the cumulative lengths and, unless the segment is flat, two divider passes
// time query first folds the time and scales it to a length on the shared divider;
//   a time before the start or after the end answers with the start or final point
// the next beat is taken while a finished result waits in the output register
// synchronous reset clears the fill count and config (repeat goes to 1); table contents are kept
module polyline_position_at_time #(
    parameter int MAX_SEGMENTS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  ppt_pkg::t_in                      i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output ppt_pkg::t_out                     o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ppt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    ppt_pkg::t_cmd w_cmd;
    ppt_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    ppt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    ppt_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an item was in progress");

    a_put_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.uop == ppt_pkg::UOP_PUT |-> w_sts.out_free)
        else $error("result written over an unsent beat");

    a_div_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.uop == ppt_pkg::UOP_T_DIV || w_cmd.uop == ppt_pkg::UOP_T_DIV2
         || w_cmd.uop == ppt_pkg::UOP_I_DIV) |-> !w_sts.div_busy)
        else $error("divider restarted while busy");

endmodule

FILE: tb/sv/polyline_position_at_time_tb.sv
// polyline_position_at_time_tb: self-checking bench for the polyline position block
// predicts each query result from its own copy of the segment table and registers
// depends on ppt_pkg and polyline_position_at_time
module polyline_position_at_time_tb;

    localparam int DEPTH = 256;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    ppt_pkg::t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    ppt_pkg::t_out o_out_data;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [ppt_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [ppt_pkg::CFG_DATA_W-1:0] i_cfg_data;

    polyline_position_at_time #(.MAX_SEGMENTS(DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    longint p_start_time, p_end_time, p_repeat, p_spatial;
    longint p_start_x, p_start_y, p_final_x, p_final_y;
    longint seg_fx[DEPTH], seg_fy[DEPTH], seg_tx[DEPTH], seg_ty[DEPTH], seg_cum[DEPTH];
    int     fill_cnt;

    ppt_pkg::t_in  pending_beats[$];
    ppt_pkg::t_out expected_pos[$];
    int   mismatches;
    bit   quiet, rx_hold, tx_hold, took;
    int   tx_gap, rx_gap;

    // generator side view of the table
    longint gen_last_cum, gen_start, gen_end;

    function automatic longint div_round_away(longint n, longint d);
        bit neg;
        longint un, ud;
        neg = (n < 0) != (d < 0);
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        return neg ? -((un + ud / 2) / ud) : (un + ud / 2) / ud;
    endfunction

    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic void pos_at_length(longint len, output longint px, output longint py);
        int lo, hi, mid, i;
        longint prev, nxt;
        if (fill_cnt == 0) begin
            px = p_start_x; py = p_start_y; return;
        end
        if (len == 0) begin
            px = seg_fx[0]; py = seg_fy[0]; return;
        end
        if (len >= seg_cum[fill_cnt-1]) begin
            px = seg_tx[fill_cnt-1]; py = seg_ty[fill_cnt-1]; return;
        end
        lo = 0; hi = fill_cnt;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (seg_cum[mid] < len) lo = mid + 1; else hi = mid;
        end
        i = (lo > fill_cnt - 1) ? fill_cnt - 1 : lo;
        nxt = seg_cum[i];
        prev = (i == 0) ? 0 : seg_cum[i-1];
        px = seg_fx[i]; py = seg_fy[i];
        if (nxt != prev) begin
            px = sat16(px + div_round_away((seg_tx[i] - px) * (len - prev), nxt - prev));
            py = sat16(py + div_round_away((seg_ty[i] - py) * (len - prev), nxt - prev));
        end
    endfunction

    function automatic void pos_at_time(longint t, output longint px, output longint py);
        longint d, e, q, r, pn, len;
        len = 0;
        if (fill_cnt == 0 || t < p_start_time) begin
            px = p_start_x; py = p_start_y; return;
        end
        if (t > p_end_time) begin
            px = p_final_x; py = p_final_y; return;
        end
        d = p_end_time - p_start_time;
        if (d != 0 && p_repeat != 0) begin
            e = (t - p_start_time) * p_repeat;
            q = e / d;
            r = e % d;
            pn = q[0] ? d - r : r;
            len = (p_spatial * pn + d / 2) / d;
        end
        pos_at_length(len, px, py);
    endfunction

    function automatic void track_beat(ppt_pkg::t_in b);
        longint x, y;
        ppt_pkg::t_out res;
        case (b.opcode)
            ppt_pkg::OPC_CLEAR: fill_cnt = 0;
            ppt_pkg::OPC_APPEND: if (fill_cnt < DEPTH) begin
                seg_fx[fill_cnt] = b.seg_from_x;
                seg_fy[fill_cnt] = b.seg_from_y;
                seg_tx[fill_cnt] = b.seg_to_x;
                seg_ty[fill_cnt] = b.seg_to_y;
                seg_cum[fill_cnt] = b.seg_total_length;
                fill_cnt++;
            end
            ppt_pkg::OPC_QTIME, ppt_pkg::OPC_QLEN: begin
                if (b.opcode == ppt_pkg::OPC_QTIME) pos_at_time(longint'(b.query_time), x, y);
                else pos_at_length(longint'(b.query_length), x, y);
                res.pos_x = x[15:0];
                res.pos_y = y[15:0];
                expected_pos.push_back(res);
            end
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #80_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // input driver
    always @(posedge i_clk) begin
        took <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) track_beat(i_in_data);
    end

    always @(negedge i_clk) begin
        if (!i_in_valid || took) begin
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                i_in_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                tx_gap <= $urandom_range(0, 4);
                i_in_valid <= 1'b0;
            end else if (pending_beats.size() != 0 && !tx_hold && i_rst_n) begin
                i_in_data <= pending_beats.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor and stall pattern
    always @(negedge i_clk) begin
        if (rx_hold) begin
            i_out_stall <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rx_gap <= $urandom_range(0, 4);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        ppt_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pos.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat x=%0d y=%0d",
                             o_out_data.pos_x, o_out_data.pos_y);
            end else begin
                want = expected_pos.pop_front();
                if (want.pos_x !== o_out_data.pos_x || want.pos_y !== o_out_data.pos_y) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("position mismatch: expected (%0d,%0d) got (%0d,%0d)",
                                 want.pos_x, want.pos_y, o_out_data.pos_x, o_out_data.pos_y);
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_beats.size() != 0 || i_in_valid || expected_pos.size() != 0)
            @(posedge i_clk);
        // appends and clears leave no result, so allow the slowest query to drain
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [ppt_pkg::CFG_IDX_W-1:0] idx, longint val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[31:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            ppt_pkg::CFG_START_TIME: p_start_time = longint'(signed'(val[31:0]));
            ppt_pkg::CFG_END_TIME:   p_end_time = longint'(signed'(val[31:0]));
            ppt_pkg::CFG_REPEAT:     p_repeat = val[7:0];
            ppt_pkg::CFG_SPATIAL:    p_spatial = val[19:0];
            ppt_pkg::CFG_START_X:    p_start_x = longint'(signed'(val[15:0]));
            ppt_pkg::CFG_START_Y:    p_start_y = longint'(signed'(val[15:0]));
            ppt_pkg::CFG_FINAL_X:    p_final_x = longint'(signed'(val[15:0]));
            ppt_pkg::CFG_FINAL_Y:    p_final_y = longint'(signed'(val[15:0]));
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(longint st, longint en, longint rep, longint spat);
        gen_start = st;
        gen_end = en;
        write_reg(ppt_pkg::CFG_START_TIME, st);
        write_reg(ppt_pkg::CFG_END_TIME, en);
        write_reg(ppt_pkg::CFG_REPEAT, rep);
        write_reg(ppt_pkg::CFG_SPATIAL, spat);
        write_reg(ppt_pkg::CFG_START_X, $urandom);
        write_reg(ppt_pkg::CFG_START_Y, $urandom);
        write_reg(ppt_pkg::CFG_FINAL_X, $urandom);
        write_reg(ppt_pkg::CFG_FINAL_Y, $urandom);
    endtask

    function automatic ppt_pkg::t_in noise_beat();
        logic [159:0] raw;
        ppt_pkg::t_in b;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        b = raw[$bits(ppt_pkg::t_in)-1:0];
        return b;
    endfunction

    task automatic push_op(logic [1:0] op, longint tq, longint lq);
        ppt_pkg::t_in b;
        b = noise_beat();
        b.opcode = op;
        b.query_time = tq[31:0];
        b.query_length = lq[19:0];
        pending_beats.push_back(b);
    endtask

    task automatic push_append(longint cum);
        ppt_pkg::t_in b;
        b = noise_beat();
        b.opcode = ppt_pkg::OPC_APPEND;
        b.seg_total_length = cum[19:0];
        pending_beats.push_back(b);
    endtask

    // clear then n appends; mostly rising lengths with the odd flat segment, random lengths when not ordered
    task automatic build_path(int n, bit ordered);
        longint cum;
        push_op(ppt_pkg::OPC_CLEAR, 0, 0);
        cum = 0;
        for (int k = 0; k < n; k++) begin
            if (!ordered) cum = $urandom_range(0, 20'hFFFFF);
            else if ($urandom_range(0, 7) != 0) cum += $urandom_range(1, 6000);
            if (cum > 20'hFFFFF) cum = 20'hFFFFF;
            push_append(cum);
        end
        gen_last_cum = cum;
    endtask

    task automatic push_query();
        longint t, d;
        int pick;
        pick = $urandom_range(0, 19);
        d = gen_end - gen_start;
        if (pick == 0) begin
            pending_beats.push_back(noise_beat());
        end else if (pick < 9) begin
            case ($urandom_range(0, 4))
                0: t = 0;
                1: t = gen_last_cum;
                2: t = gen_last_cum + $urandom_range(0, 50);
                3: t = $urandom_range(0, 20'hFFFFF);
                default: t = $urandom_range(0, gen_last_cum);
            endcase
            push_op(ppt_pkg::OPC_QLEN, 0, t > 20'hFFFFF ? 20'hFFFFF : t);
        end else begin
            case ($urandom_range(0, 6))
                0: t = gen_start - $urandom_range(1, 100);
                1: t = gen_end + $urandom_range(1, 100);
                2: t = gen_start;
                3: t = gen_end;
                4: t = longint'(signed'($urandom));
                default: t = (d > 0) ? gen_start + ({$urandom, $urandom} % (d + 1)) : gen_start;
            endcase
            if (t > 64'sd2147483647) t = 64'sd2147483647;
            if (t < -64'sd2147483648) t = -64'sd2147483648;
            push_op(ppt_pkg::OPC_QTIME, t, 0);
        end
    endtask

    initial begin
        longint st, en, spat;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        p_start_time = 0; p_end_time = 0; p_repeat = 1; p_spatial = 0;
        p_start_x = 0; p_start_y = 0; p_final_x = 0; p_final_y = 0;
        fill_cnt = 0;
        mismatches = 0;
        quiet = 0; rx_hold = 0; tx_hold = 0; took = 0;
        tx_gap = 0; rx_gap = 0;
        gen_last_cum = 0; gen_start = 0; gen_end = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, zero duration, ends, flat segment, overflow
        push_op(ppt_pkg::OPC_QLEN, 0, 100);
        push_op(ppt_pkg::OPC_QTIME, 0, 0);
        build_path(3, 1);
        push_append(gen_last_cum);
        push_op(ppt_pkg::OPC_QTIME, 0, 0);
        push_op(ppt_pkg::OPC_QTIME, -1, 0);
        push_op(ppt_pkg::OPC_QTIME, 1, 0);
        push_op(ppt_pkg::OPC_QLEN, 0, 0);
        push_op(ppt_pkg::OPC_QLEN, 0, 20'hFFFFF);
        push_op(ppt_pkg::OPC_QLEN, 0, gen_last_cum / 2);
        push_op(ppt_pkg::OPC_QLEN, 0, 1);
        wait_idle();
        write_all(-64'sd2147483648, 64'sd2147483647, 255, 20'hFFFFF);
        build_path(DEPTH, 1);
        push_append(5);
        for (int k = 0; k < 6; k++) push_query();
        push_op(ppt_pkg::OPC_QTIME, -64'sd2147483648, 0);
        push_op(ppt_pkg::OPC_QTIME, 64'sd2147483647, 0);
        wait_idle();

        for (int ph = 0; ph < 14; ph++) begin
            quiet = (ph >= 12);
            st = longint'(signed'($urandom));
            case ($urandom_range(0, 3))
                0: en = st;
                1: en = st + $urandom_range(1, 50);
                2: en = st + $urandom_range(1, 200000);
                default: en = longint'(signed'($urandom));
            endcase
            if (en > 64'sd2147483647) en = 64'sd2147483647;
            spat = ($urandom_range(0, 1) != 0) ? gen_last_cum : $urandom_range(0, 20'hFFFFF);
            write_all(st, en, (ph == 5) ? 1 : $urandom_range(1, 255), spat);
            build_path((ph == 7) ? DEPTH + 2 : $urandom_range(1, 16), ph != 9);
            if (ph == 8) pending_beats.push_back(noise_beat());
            if (ph == 3) begin
                // hold the result side long enough for the input to back up
                rx_hold = 1;
                for (int k = 0; k < 40; k++) push_query();
                fork
                    begin
                        repeat (3000) @(posedge i_clk);
                        rx_hold = 0;
                    end
                join_none
            end
            if (ph == 6) begin
                for (int k = 0; k < 20; k++) push_query();
                tx_hold = 1;
                while (expected_pos.size() != 0 || i_in_valid)
                    @(posedge i_clk);
                tx_hold = 0;
            end
            for (int k = 0; k < 75; k++) begin
                if ($urandom_range(0, 40) == 0) build_path($urandom_range(0, 6), 1);
                push_query();
            end
            wait_idle();
        end

        if (expected_pos.size() == 0 && mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
